// ===== rtl/elevator_request_scan_controller_assert.svh =====
// Assertion macros used by the scan controller datapath.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ELEVATOR_REQUEST_SCAN_CONTROLLER_ASSERT_SVH
`define ELEVATOR_REQUEST_SCAN_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ersc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ersc_pkg
// Codes, control word layout and microprogram of the elevator scan controller.
// ----------------------------------------------------------------------------
package ersc_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_HALL = 2'd1;
    localparam logic [1:0] OP_CAR  = 2'd2;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PASSED  = 2'd1;
    localparam logic [1:0] ST_ARRIVED = 2'd2;

    typedef logic [2:0] act_t;
    typedef logic [2:0] cond_t;
    typedef logic [3:0] step_t;

    localparam act_t ACT_NONE      = 3'd0;
    localparam act_t ACT_ACCEPT    = 3'd1;
    localparam act_t ACT_SET_CALL  = 3'd2;
    localparam act_t ACT_SCAN_INIT = 3'd3;
    localparam act_t ACT_SCAN_ADV  = 3'd4;
    localparam act_t ACT_MOVE      = 3'd5;
    localparam act_t ACT_DELIVER   = 3'd6;

    localparam cond_t COND_NEVER     = 3'd0;
    localparam cond_t COND_ALWAYS    = 3'd1;
    localparam cond_t COND_NO_ITEM   = 3'd2;
    localparam cond_t COND_NOT_TICK  = 3'd3;
    localparam cond_t COND_SLOT_HIT  = 3'd4;
    localparam cond_t COND_SCAN_MORE = 3'd5;
    localparam cond_t COND_OUT_BUSY  = 3'd6;

    localparam step_t STEP_WAIT      = 4'd0;
    localparam step_t STEP_DISPATCH  = 4'd1;
    localparam step_t STEP_SCAN_INIT = 4'd2;
    localparam step_t STEP_SCAN_TEST = 4'd3;
    localparam step_t STEP_SCAN_ADV  = 4'd4;
    localparam step_t STEP_WAIT_OUT  = 4'd5;
    localparam step_t STEP_DELIVER   = 4'd6;
    localparam step_t STEP_MOVE      = 4'd7;
    localparam step_t STEP_CALL      = 4'd8;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic no_item;
        logic not_tick;
        logic slot_hit;
        logic scan_more;
        logic out_busy;
    } flags_t;

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            STEP_WAIT:      w = '{ACT_ACCEPT,    COND_NO_ITEM,   STEP_WAIT};
            STEP_DISPATCH:  w = '{ACT_NONE,      COND_NOT_TICK,  STEP_CALL};
            STEP_SCAN_INIT: w = '{ACT_SCAN_INIT, COND_NEVER,     STEP_WAIT};
            STEP_SCAN_TEST: w = '{ACT_NONE,      COND_SLOT_HIT,  STEP_MOVE};
            STEP_SCAN_ADV:  w = '{ACT_SCAN_ADV,  COND_SCAN_MORE, STEP_SCAN_TEST};
            STEP_WAIT_OUT:  w = '{ACT_NONE,      COND_OUT_BUSY,  STEP_WAIT_OUT};
            STEP_DELIVER:   w = '{ACT_DELIVER,   COND_ALWAYS,    STEP_WAIT};
            STEP_MOVE:      w = '{ACT_MOVE,      COND_ALWAYS,    STEP_WAIT_OUT};
            STEP_CALL:      w = '{ACT_SET_CALL,  COND_ALWAYS,    STEP_WAIT_OUT};
            default:        w = '{ACT_NONE,      COND_ALWAYS,    STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ersc_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ersc_sequencer
// Step counter and microprogram table with conditional jumps.
// ----------------------------------------------------------------------------
module ersc_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  ersc_pkg::flags_t flags,
    output ersc_pkg::uword_t ctrl
);
    import ersc_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  take;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_ITEM:   take = flags.no_item;
            COND_NOT_TICK:  take = flags.not_tick;
            COND_SLOT_HIT:  take = flags.slot_hit;
            COND_SCAN_MORE: take = flags.scan_more;
            COND_OUT_BUSY:  take = flags.out_busy;
            default:        take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/ersc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ersc_datapath
// Call vector, scan pointer, car position and the output word register.
// ----------------------------------------------------------------------------
module ersc_datapath #(
    parameter int FLOORS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ersc_pkg::uword_t ctrl,
    output ersc_pkg::flags_t flags,
    input  logic             call_valid,
    output logic             call_stall,
    input  logic [1:0]       op,
    input  logic [3:0]       floor,
    input  logic             going_up,
    output logic             report_valid,
    input  logic             report_stall,
    output logic [3:0]       car_floor_out,
    output logic             moving_up,
    output logic [1:0]       status
);
    import ersc_pkg::*;

    `include "elevator_request_scan_controller_assert.svh"

    localparam int SLOTS = 2 * FLOORS;
    localparam int SW    = $clog2(SLOTS);
    localparam int FW    = $clog2(FLOORS + 1);
    localparam int DW    = SW + 1;

    logic [1:0]       item_op_reg;
    logic [3:0]       item_floor_reg;
    logic             item_up_reg;
    logic [SLOTS-1:0] call_slots_reg, call_slots_next;
    logic [SW-1:0]    scan_start_reg, scan_start_next;
    logic [SW-1:0]    scan_idx_reg, scan_idx_next;
    logic [SW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [FW-1:0]    car_floor_reg, car_floor_next;
    logic             travel_up_reg, travel_up_next;
    logic [1:0]       status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       car_floor_out_reg;
    logic             moving_up_reg;
    logic [1:0]       status_out_reg;

    logic             accept;
    logic [DW-1:0]    idx_w;
    logic             hit_up;
    logic [FW-1:0]    tgt_floor;
    logic [FW-1:0]    car_step;
    logic             arrived;
    logic [SW-1:0]    pass_slot;
    logic             call_up;
    logic             call_ok;
    logic [SW-1:0]    call_slot;

    assign accept     = (ctrl.act == ACT_ACCEPT) && call_valid;
    assign call_stall = (ctrl.act != ACT_ACCEPT);

    assign idx_w     = DW'(scan_idx_reg);
    assign hit_up    = idx_w >= DW'(FLOORS);
    assign tgt_floor = hit_up ? FW'(idx_w - DW'(FLOORS - 1)) : FW'(DW'(FLOORS) - idx_w);
    assign car_step  = (car_floor_reg > tgt_floor) ? car_floor_reg - FW'(1) :
                       (car_floor_reg < tgt_floor) ? car_floor_reg + FW'(1) : car_floor_reg;
    assign arrived   = (car_step == tgt_floor);
    assign pass_slot = hit_up ? SW'(DW'(FLOORS - 1) + DW'(car_step))
                              : SW'(DW'(FLOORS) - DW'(car_step));

    assign call_up   = (item_op_reg == OP_HALL) ? item_up_reg : travel_up_reg;
    assign call_ok   = ((item_op_reg == OP_HALL) || (item_op_reg == OP_CAR)) &&
                       (item_floor_reg != 4'd0) && (int'(item_floor_reg) <= FLOORS);
    assign call_slot = call_up ? SW'(DW'(FLOORS - 1) + DW'(item_floor_reg))
                               : SW'(DW'(FLOORS) - DW'(item_floor_reg));

    assign flags.no_item   = !call_valid;
    assign flags.not_tick  = (item_op_reg != OP_TICK);
    assign flags.slot_hit  = call_slots_reg[scan_idx_reg];
    assign flags.scan_more = (scan_cnt_reg != SW'(SLOTS - 1));
    assign flags.out_busy  = out_valid_reg && report_stall;

    always_comb
    begin
        call_slots_next = call_slots_reg;
        scan_start_next = scan_start_reg;
        scan_idx_next   = scan_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        car_floor_next  = car_floor_reg;
        travel_up_next  = travel_up_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && report_stall;
        unique case (ctrl.act)
            ACT_SET_CALL:
            begin
                status_next = ST_IDLE;
                if (call_ok)
                begin
                    call_slots_next[call_slot] = 1'b1;
                end
            end
            ACT_SCAN_INIT:
            begin
                status_next   = ST_IDLE;
                scan_cnt_next = '0;
                scan_idx_next = (scan_start_reg == SW'(SLOTS - 1)) ? '0
                                : scan_start_reg + SW'(1);
            end
            ACT_SCAN_ADV:
            begin
                scan_cnt_next = scan_cnt_reg + SW'(1);
                scan_idx_next = (scan_idx_reg == SW'(SLOTS - 1)) ? '0
                                : scan_idx_reg + SW'(1);
            end
            ACT_MOVE:
            begin
                car_floor_next = car_step;
                if (car_floor_reg != tgt_floor)
                begin
                    travel_up_next = (car_floor_reg < tgt_floor);
                end
                if (arrived)
                begin
                    call_slots_next[scan_idx_reg] = 1'b0;
                    scan_start_next = scan_idx_reg;
                    status_next     = ST_ARRIVED;
                end
                else
                begin
                    scan_start_next = pass_slot;
                    status_next     = ST_PASSED;
                end
            end
            ACT_DELIVER:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_slots_reg <= '0;
            scan_start_reg <= '0;
            car_floor_reg  <= FW'(1);
            travel_up_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            call_slots_reg <= call_slots_next;
            scan_start_reg <= scan_start_next;
            car_floor_reg  <= car_floor_next;
            travel_up_reg  <= travel_up_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        scan_cnt_reg <= scan_cnt_next;
        status_reg   <= status_next;
        if (accept)
        begin
            item_op_reg    <= op;
            item_floor_reg <= floor;
            item_up_reg    <= going_up;
        end
        if (ctrl.act == ACT_DELIVER)
        begin
            car_floor_out_reg <= 4'(car_floor_reg);
            moving_up_reg     <= travel_up_reg;
            status_out_reg    <= status_reg;
        end
    end

    assign report_valid  = out_valid_reg;
    assign car_floor_out = car_floor_out_reg;
    assign moving_up     = moving_up_reg;
    assign status        = status_out_reg;

    `ERSC_ASSERT_NOW(a_car_in_range, 1'b1,
        (car_floor_reg != '0) && (int'(car_floor_reg) <= FLOORS),
        "Car floor left the range of served floors.")
    `ERSC_ASSERT_NEXT(a_car_only_on_move, ctrl.act != ACT_MOVE, $stable(car_floor_reg),
        "Car floor changed outside a move step.")
    `ERSC_ASSERT_NEXT(a_arrival_clears, (ctrl.act == ACT_MOVE) && arrived,
        (scan_start_reg == $past(scan_idx_reg)) && !call_slots_reg[$past(scan_idx_reg)],
        "Arrival did not clear the served slot or move the scan start onto it.")
    `ERSC_ASSERT_NOW(a_no_overwrite, ctrl.act == ACT_DELIVER,
        !(out_valid_reg && report_stall),
        "A new word was loaded over a word still waiting at the output.")

endmodule

// ===== rtl/elevator_request_scan_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_request_scan_controller
// Elevator call scheduler with a circular scan over up and down call slots.
// ----------------------------------------------------------------------------
// Each accepted word is a time tick, a hall call or a car call, and yields
// exactly one report word with the car floor, travel direction and status.
// A small microprogram steps a plain datapath. A call word sets its slot and
// goes on to the report; a tick scans the slots, starting after the scan start,
// until it finds a set one, which it steps the car toward, or has tested them
// all; it tests one slot in one step and advances the pointer in the next.
// A new word is accepted only once the previous report has been loaded into
// the output register, which holds it until the receiver takes it.
module elevator_request_scan_controller #(
    parameter int FLOORS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       call_valid,
    output logic       call_stall,
    input  logic [1:0] op,
    input  logic [3:0] floor,
    input  logic       going_up,
    output logic       report_valid,
    input  logic       report_stall,
    output logic [3:0] car_floor_out,
    output logic       moving_up,
    output logic [1:0] status
);
    import ersc_pkg::*;

    uword_t ctrl;
    flags_t flags;

    ersc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    ersc_datapath #(
        .FLOORS (FLOORS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .flags         (flags),
        .call_valid    (call_valid),
        .call_stall    (call_stall),
        .op            (op),
        .floor         (floor),
        .going_up      (going_up),
        .report_valid  (report_valid),
        .report_stall  (report_stall),
        .car_floor_out (car_floor_out),
        .moving_up     (moving_up),
        .status        (status)
    );

endmodule
